[sv/srht_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Segment / rectangle edge hit test: shared package
// Widths, orientation codes, edge and corner indexes, pipeline stage types.
// ----------------------------------------------------------------------------
package srht_pkg;

   localparam int COORD_WIDTH = 12;
   localparam int RECT_WIDTH  = 10;
   // rect corners reach 2*(2^RECT_WIDTH - 1): RECT_WIDTH+1 bits unsigned
   localparam int EXT_WIDTH   = RECT_WIDTH + 1;
   localparam int CMP_W       = (COORD_WIDTH > EXT_WIDTH + 1) ? COORD_WIDTH : EXT_WIDTH + 1;
   localparam int DIF_W       = CMP_W + 1;
   localparam int PRD_W       = 2 * DIF_W;
   localparam int CRS_W       = PRD_W + 1;

   localparam int NUM_EDGES   = 4;
   localparam int NUM_CORNERS = 4;

   localparam int EDGE_LEFT   = 0;
   localparam int EDGE_TOP    = 1;
   localparam int EDGE_RIGHT  = 2;
   localparam int EDGE_BOTTOM = 3;

   localparam int CORNER_LT   = 0;
   localparam int CORNER_RT   = 1;
   localparam int CORNER_LB   = 2;
   localparam int CORNER_RB   = 3;

   typedef enum logic [1:0] {
      ORI_COLIN = 2'd0,
      ORI_CW    = 2'd1,
      ORI_CCW   = 2'd2
   } orient_type;

   // edge-side orientation and bounding-box results, settled in the first stage
   typedef struct packed {
      orient_type [NUM_EDGES-1:0]   o3;
      orient_type [NUM_EDGES-1:0]   o4;
      logic       [NUM_CORNERS-1:0] cbox;
      logic       [NUM_EDGES-1:0]   pbox;
      logic       [NUM_EDGES-1:0]   qbox;
   } edge_info_type;

   typedef struct packed {
      logic signed [DIF_W-1:0] dx;
      logic signed [DIF_W-1:0] dy;
      logic signed [DIF_W-1:0] exl;
      logic signed [DIF_W-1:0] exr;
      logic signed [DIF_W-1:0] eyt;
      logic signed [DIF_W-1:0] eyb;
   } delta_type;

   typedef struct packed {
      logic signed [PRD_W-1:0] dy_l;
      logic signed [PRD_W-1:0] dy_r;
      logic signed [PRD_W-1:0] dx_t;
      logic signed [PRD_W-1:0] dx_b;
   } prod_type;

endpackage

[sv/segment_rect_edge_hit_test.sv]
`timescale 1ns / 1ps
// A request accepted at a clock edge is captured in stage one, registered in
// stages two, three and four, and then shows on rsp_valid. Throughput: one
// request per cycle when not stalled; each stage advances when the next one
// is empty or advancing, so bubbles collapse and a stall drops nothing.
// Reset clears the stage valid bits; payload registers are not reset.
// ----------------------------------------------------------------------------
// Segment / rectangle edge hit test
// Pipelined orientation test of one segment against each edge of an
// axis-aligned rectangle: deltas and compares, products, cross signs, combine.
// ----------------------------------------------------------------------------
module segment_rect_edge_hit_test (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic signed [srht_pkg::COORD_WIDTH-1:0] req_line_start_x,
   input  logic signed [srht_pkg::COORD_WIDTH-1:0] req_line_start_y,
   input  logic signed [srht_pkg::COORD_WIDTH-1:0] req_line_end_x,
   input  logic signed [srht_pkg::COORD_WIDTH-1:0] req_line_end_y,
   input  logic        [srht_pkg::RECT_WIDTH-1:0]  req_rect_left,
   input  logic        [srht_pkg::RECT_WIDTH-1:0]  req_rect_top,
   input  logic        [srht_pkg::RECT_WIDTH-1:0]  req_rect_width,
   input  logic        [srht_pkg::RECT_WIDTH-1:0]  req_rect_height,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic                                   rsp_edge_hit
);
   import srht_pkg::*;

   // orientation of a point against an axis-aligned edge: only the side matters
   function automatic orient_type side_code(input logic zero_len,
                                            input logic signed [CMP_W-1:0] a,
                                            input logic signed [CMP_W-1:0] b,
                                            input logic flip);
      orient_type code;
      if (zero_len || a == b) begin
         code = ORI_COLIN;
      end else if ((a > b) ^ flip) begin
         code = ORI_CW;
      end else begin
         code = ORI_CCW;
      end
      return code;
   endfunction

   function automatic logic between(input logic signed [CMP_W-1:0] v,
                                    input logic signed [CMP_W-1:0] a,
                                    input logic signed [CMP_W-1:0] b);
      return (v >= a && v <= b) || (v >= b && v <= a);
   endfunction

   function automatic orient_type cross_code(input logic signed [CRS_W-1:0] v);
      orient_type code;
      if (v == '0) begin
         code = ORI_COLIN;
      end else if (v[CRS_W-1]) begin
         code = ORI_CCW;
      end else begin
         code = ORI_CW;
      end
      return code;
   endfunction

   function automatic logic one_edge(input orient_type o1, input orient_type o2,
                                     input orient_type o3, input orient_type o4,
                                     input logic box_a, input logic box_b,
                                     input logic box_p, input logic box_q);
      return (o1 != o2 && o3 != o4) ||
             (o1 == ORI_COLIN && box_a) || (o2 == ORI_COLIN && box_b) ||
             (o3 == ORI_COLIN && box_p) || (o4 == ORI_COLIN && box_q);
   endfunction

   // stage control
   logic s1_valid_ff, s2_valid_ff, s3_valid_ff, rsp_valid_ff;
   logic adv1, adv2, adv3, adv4;

   // stage payloads
   delta_type                    s1_delta_in, s1_delta_ff;
   edge_info_type                s1_info_in,  s1_info_ff, s2_info_ff, s3_info_ff;
   prod_type                     s2_prod_in,  s2_prod_ff;
   orient_type [NUM_CORNERS-1:0] s3_corner_in, s3_corner_ff;
   logic                         rsp_edge_hit_in, rsp_edge_hit_ff;

   // stage 1 operands
   logic signed [CMP_W-1:0] px, py, qx, qy, cl, ct, cr, cb;
   logic        [EXT_WIDTH-1:0] right_sum, bottom_sum;
   logic                    w_zero, h_zero;
   logic signed [CRS_W-1:0] crs [NUM_CORNERS];

   assign adv4      = !rsp_valid_ff || !rsp_stall;
   assign adv3      = !s3_valid_ff  || adv4;
   assign adv2      = !s2_valid_ff  || adv3;
   assign adv1      = !s1_valid_ff  || adv2;
   assign req_stall = !adv1;

   // stage 1: deltas, edge sides, bounding boxes
   always_comb begin
      px = CMP_W'(req_line_start_x);
      py = CMP_W'(req_line_start_y);
      qx = CMP_W'(req_line_end_x);
      qy = CMP_W'(req_line_end_y);

      right_sum  = EXT_WIDTH'(req_rect_left) + EXT_WIDTH'(req_rect_width);
      bottom_sum = EXT_WIDTH'(req_rect_top)  + EXT_WIDTH'(req_rect_height);

      cl = signed'(CMP_W'(req_rect_left));
      ct = signed'(CMP_W'(req_rect_top));
      cr = signed'(CMP_W'(right_sum));
      cb = signed'(CMP_W'(bottom_sum));

      w_zero = (req_rect_width == '0);
      h_zero = (req_rect_height == '0);

      s1_delta_in.dx  = DIF_W'(qx) - DIF_W'(px);
      s1_delta_in.dy  = DIF_W'(qy) - DIF_W'(py);
      s1_delta_in.exl = DIF_W'(cl) - DIF_W'(qx);
      s1_delta_in.exr = DIF_W'(cr) - DIF_W'(qx);
      s1_delta_in.eyt = DIF_W'(ct) - DIF_W'(qy);
      s1_delta_in.eyb = DIF_W'(cb) - DIF_W'(qy);

      // top and bottom edges run left to right, so their sign flips
      s1_info_in.o3[EDGE_LEFT]   = side_code(h_zero, px, cl, 1'b0);
      s1_info_in.o3[EDGE_TOP]    = side_code(w_zero, py, ct, 1'b1);
      s1_info_in.o3[EDGE_RIGHT]  = side_code(h_zero, px, cr, 1'b0);
      s1_info_in.o3[EDGE_BOTTOM] = side_code(w_zero, py, cb, 1'b1);
      s1_info_in.o4[EDGE_LEFT]   = side_code(h_zero, qx, cl, 1'b0);
      s1_info_in.o4[EDGE_TOP]    = side_code(w_zero, qy, ct, 1'b1);
      s1_info_in.o4[EDGE_RIGHT]  = side_code(h_zero, qx, cr, 1'b0);
      s1_info_in.o4[EDGE_BOTTOM] = side_code(w_zero, qy, cb, 1'b1);

      s1_info_in.cbox[CORNER_LT] = between(cl, px, qx) && between(ct, py, qy);
      s1_info_in.cbox[CORNER_RT] = between(cr, px, qx) && between(ct, py, qy);
      s1_info_in.cbox[CORNER_LB] = between(cl, px, qx) && between(cb, py, qy);
      s1_info_in.cbox[CORNER_RB] = between(cr, px, qx) && between(cb, py, qy);

      s1_info_in.pbox[EDGE_LEFT]   = (px == cl) && py >= ct && py <= cb;
      s1_info_in.pbox[EDGE_TOP]    = (py == ct) && px >= cl && px <= cr;
      s1_info_in.pbox[EDGE_RIGHT]  = (px == cr) && py >= ct && py <= cb;
      s1_info_in.pbox[EDGE_BOTTOM] = (py == cb) && px >= cl && px <= cr;
      s1_info_in.qbox[EDGE_LEFT]   = (qx == cl) && qy >= ct && qy <= cb;
      s1_info_in.qbox[EDGE_TOP]    = (qy == ct) && qx >= cl && qx <= cr;
      s1_info_in.qbox[EDGE_RIGHT]  = (qx == cr) && qy >= ct && qy <= cb;
      s1_info_in.qbox[EDGE_BOTTOM] = (qy == cb) && qx >= cl && qx <= cr;
   end

   // stage 2: the four products shared by the corner cross products
   always_comb begin
      s2_prod_in.dy_l = signed'(s1_delta_ff.dy) * signed'(s1_delta_ff.exl);
      s2_prod_in.dy_r = signed'(s1_delta_ff.dy) * signed'(s1_delta_ff.exr);
      s2_prod_in.dx_t = signed'(s1_delta_ff.dx) * signed'(s1_delta_ff.eyt);
      s2_prod_in.dx_b = signed'(s1_delta_ff.dx) * signed'(s1_delta_ff.eyb);
   end

   // stage 3: orientation of each corner against the segment
   always_comb begin
      crs[CORNER_LT] = signed'(s2_prod_ff.dy_l) - signed'(s2_prod_ff.dx_t);
      crs[CORNER_RT] = signed'(s2_prod_ff.dy_r) - signed'(s2_prod_ff.dx_t);
      crs[CORNER_LB] = signed'(s2_prod_ff.dy_l) - signed'(s2_prod_ff.dx_b);
      crs[CORNER_RB] = signed'(s2_prod_ff.dy_r) - signed'(s2_prod_ff.dx_b);
      for (int i = 0; i < NUM_CORNERS; i++) begin
         s3_corner_in[i] = cross_code(crs[i]);
      end
   end

   // stage 4: OR together the left, top, right and bottom edge tests
   always_comb begin
      rsp_edge_hit_in =
         one_edge(s3_corner_ff[CORNER_LT], s3_corner_ff[CORNER_LB],
                  s3_info_ff.o3[EDGE_LEFT], s3_info_ff.o4[EDGE_LEFT],
                  s3_info_ff.cbox[CORNER_LT], s3_info_ff.cbox[CORNER_LB],
                  s3_info_ff.pbox[EDGE_LEFT], s3_info_ff.qbox[EDGE_LEFT]) ||
         one_edge(s3_corner_ff[CORNER_LT], s3_corner_ff[CORNER_RT],
                  s3_info_ff.o3[EDGE_TOP], s3_info_ff.o4[EDGE_TOP],
                  s3_info_ff.cbox[CORNER_LT], s3_info_ff.cbox[CORNER_RT],
                  s3_info_ff.pbox[EDGE_TOP], s3_info_ff.qbox[EDGE_TOP]) ||
         one_edge(s3_corner_ff[CORNER_RT], s3_corner_ff[CORNER_RB],
                  s3_info_ff.o3[EDGE_RIGHT], s3_info_ff.o4[EDGE_RIGHT],
                  s3_info_ff.cbox[CORNER_RT], s3_info_ff.cbox[CORNER_RB],
                  s3_info_ff.pbox[EDGE_RIGHT], s3_info_ff.qbox[EDGE_RIGHT]) ||
         one_edge(s3_corner_ff[CORNER_LB], s3_corner_ff[CORNER_RB],
                  s3_info_ff.o3[EDGE_BOTTOM], s3_info_ff.o4[EDGE_BOTTOM],
                  s3_info_ff.cbox[CORNER_LB], s3_info_ff.cbox[CORNER_RB],
                  s3_info_ff.pbox[EDGE_BOTTOM], s3_info_ff.qbox[EDGE_BOTTOM]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (adv1) begin
            s1_valid_ff <= req_valid;
         end
         if (adv2) begin
            s2_valid_ff <= s1_valid_ff;
         end
         if (adv3) begin
            s3_valid_ff <= s2_valid_ff;
         end
         if (adv4) begin
            rsp_valid_ff <= s3_valid_ff;
         end
      end
   end

   // hold each payload while its stage is blocked
   always_ff @(posedge clock) begin
      if (adv1) begin
         s1_delta_ff <= s1_delta_in;
         s1_info_ff  <= s1_info_in;
      end
      if (adv2) begin
         s2_prod_ff <= s2_prod_in;
         s2_info_ff <= s1_info_ff;
      end
      if (adv3) begin
         s3_corner_ff <= s3_corner_in;
         s3_info_ff   <= s2_info_ff;
      end
      if (adv4) begin
         rsp_edge_hit_ff <= rsp_edge_hit_in;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_edge_hit = rsp_edge_hit_ff;

endmodule

[sv/srht_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Segment / rectangle edge hit test: port checker
// Watches the top-level ports for reset, stall and latency behavior.
// ----------------------------------------------------------------------------
module srht_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_stall,
   input logic rsp_valid,
   input logic rsp_stall,
   input logic rsp_edge_hit
);

   logic req_seen;

   assign req_seen = req_valid && !req_stall;

   // no response may be pending right after reset
   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   // the input only backs up when the whole pipe is full and the output is stalled
   a_stall_source: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("request stalled while pipeline has room");

   // with the output free, a request passes each stage register and then comes out
   a_latency: assert property (@(posedge clock) disable iff (reset)
      req_seen ##1 !rsp_stall ##1 !rsp_stall ##1 !rsp_stall |=> rsp_valid)
      else $error("response missing after pipeline latency");

   // a stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_edge_hit))
      else $error("stalled response changed");

endmodule

bind segment_rect_edge_hit_test srht_checker u_srht_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_valid),
   .req_stall    (req_stall),
   .rsp_valid    (rsp_valid),
   .rsp_stall    (rsp_stall),
   .rsp_edge_hit (rsp_edge_hit)
);
